FILE: hw/rtl/cs9_pkg.sv
// Shared types, constants and helper functions of the cubemap SH9 projection block.
`default_nettype none

package cs9_pkg;

  localparam int MAX_FACE_SIZE = 256;
  localparam int FSZ_W = 9;
  localparam logic [FSZ_W-1:0] FACE_SIZE_RST = 9'd256;

  localparam int MUL_W = 34;
  localparam int PROD_W = 68;
  localparam int DIV_NUM_W = 68;
  localparam int DIV_DEN_W = 44;
  localparam int DIV_CNT_W = 7;
  localparam int SQ_W = 64;
  localparam int SQ_CNT_W = 5;
  localparam int ACC_W = 48;
  localparam int WT_W = 40;
  localparam int NUM_ACC = 27;
  localparam int NUM_COEFF = 9;
  localparam int BASIS_W = 18;
  localparam int ACC_IDX_W = 5;

  localparam logic [2:0] FACE_PX = 3'd0;
  localparam logic [2:0] FACE_NX = 3'd1;
  localparam logic [2:0] FACE_PY = 3'd2;
  localparam logic [2:0] FACE_NY = 3'd3;
  localparam logic [2:0] FACE_PZ = 3'd4;
  localparam logic [2:0] FACE_NZ = 3'd5;

  localparam logic [3:0] LAST_COEFF = 4'd8;

  localparam logic signed [BASIS_W-1:0] Y0_VAL = 18'sd9244;
  localparam logic [BASIS_W-1:0] K_BAND1 = 18'd32021;
  localparam logic [BASIS_W-1:0] K_CROSS = 18'd71601;
  localparam logic [BASIS_W-1:0] K_ZONAL = 18'd20670;
  localparam logic [BASIS_W-1:0] K_DIFF = 18'd35801;
  localparam logic [19:0] FOURPI_Q16 = 20'd823549;

  typedef struct packed {
    logic [2:0]  face_index;
    logic [7:0]  column;
    logic [7:0]  row;
    logic [15:0] red_sample;
    logic [15:0] green_sample;
    logic [15:0] blue_sample;
    logic        final_texel;
  } texel_t;

  typedef struct packed {
    logic [3:0]         coeff_index;
    logic signed [31:0] red_coeff;
    logic signed [31:0] green_coeff;
    logic signed [31:0] blue_coeff;
    logic               last_coeff;
  } coeff_t;

  typedef enum logic [5:0] {
    ST_IDLE, ST_U_DIV, ST_U_WAIT, ST_V_DIV, ST_V_WAIT,
    ST_UU_MUL, ST_UU_GET, ST_VV_MUL, ST_VV_GET, ST_SQ_START, ST_SQ_WAIT,
    ST_P_MUL, ST_P_GET, ST_W_DIV, ST_W_WAIT, ST_R_DIV, ST_R_WAIT,
    ST_N_MUL, ST_N_GET, ST_B_SEL, ST_PR_MUL, ST_PR_GET, ST_YY_MUL, ST_YY_GET,
    ST_C_MUL, ST_C_GET, ST_WS_MUL, ST_WS_GET, ST_T_MUL, ST_T_ADD, ST_WT_ADD,
    ST_FIN, ST_O_LO_MUL, ST_O_LO_GET, ST_O_HI_MUL, ST_O_HI_GET, ST_O_DIV,
    ST_O_WAIT, ST_O_PUSH
  } state_t;

  // Arithmetic right shift with rounding to nearest, ties away from zero.
  function automatic logic signed [PROD_W-1:0] rnd_shift(
      input logic signed [PROD_W-1:0] val, input int sh);
    logic signed [PROD_W-1:0] bias;
    bias = signed'((PROD_W'(1) << (sh - 1)) - PROD_W'(val[PROD_W-1]));
    return (val + bias) >>> sh;
  endfunction

  function automatic logic [ACC_IDX_W-1:0] acc_index(input logic [3:0] k,
                                                     input logic [1:0] ch);
    return ACC_IDX_W'({k, 1'b0}) + ACC_IDX_W'(k) + ACC_IDX_W'(ch);
  endfunction

  function automatic logic [BASIS_W-1:0] basis_const(input logic [3:0] k);
    logic [BASIS_W-1:0] c;
    case (k) inside
      4'd1, 4'd2, 4'd3: c = K_BAND1;
      4'd4, 4'd5, 4'd7: c = K_CROSS;
      4'd6:             c = K_ZONAL;
      default:          c = K_DIFF;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/cubemap_sh9_projection.sv
// Top level of the cubemap to order-3 spherical harmonics projection block.
//
//  channel | signals                          | transaction
//  --------+----------------------------------+-------------------------------------
//  config  | cfg_we, cfg_wdata                | face_size written when cfg_we is high
//  input   | in_valid, in_ready, texel        | one texel, accepted on valid & ready
//  output  | out_valid, out_ready, coeff      | one coefficient triple, nine per cubemap
//
// A texel on a valid face goes through four divisions on the one-bit-per-cycle
// divider, a square root, and sequencing around the shared multiplier (50
// products, plus basis selects). A texel on an unused face skips to the final
// step. A final texel then adds 27 output scalings, each two partial products
// and one more division (none when the weight sum is zero, which gives zero),
// and then hands over the nine results.
// Reset is synchronous and clears the accumulators, the weight sum and
// face_size (to 256). A stalled output holds only the last result; each
// handover waits while the output register is full, and the next texel is
// accepted while the last result still waits in the output register.
`default_nettype none

module cubemap_sh9_projection (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [cs9_pkg::FSZ_W-1:0]  cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  cs9_pkg::texel_t            texel,
  output logic                       out_valid,
  input  logic                       out_ready,
  output cs9_pkg::coeff_t            coeff
);

  logic [cs9_pkg::FSZ_W-1:0] face_size;
  logic [cs9_pkg::FSZ_W-1:0] n_eff;
  logic                      core_idle;
  logic                      out_free;
  logic                      push;
  cs9_pkg::coeff_t           result;

  // Face size register. Zero acts as one; anything above the supported
  // maximum is clamped to it.
  always_ff @(posedge clk) begin
    if (rst) begin
      face_size <= cs9_pkg::FACE_SIZE_RST;
    end else if (cfg_we) begin
      face_size <= cfg_wdata;
    end
  end

  always_comb begin
    if (face_size == '0) begin
      n_eff = cs9_pkg::FSZ_W'(1);
    end else if (face_size > cs9_pkg::FSZ_W'(cs9_pkg::MAX_FACE_SIZE)) begin
      n_eff = cs9_pkg::FSZ_W'(cs9_pkg::MAX_FACE_SIZE);
    end else begin
      n_eff = face_size;
    end
  end

  // The sequencer takes one texel at a time.
  assign in_ready = core_idle;

  // The output register frees up in the cycle its content is taken.
  assign out_free = !out_valid || out_ready;

  cs9_core u_core (
    .clk(clk), .rst(rst),
    .start(in_valid && in_ready), .texel(texel), .n_in(n_eff),
    .idle(core_idle), .out_free(out_free), .push(push), .result(result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      coeff <= result;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/cs9_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none

module cs9_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [cs9_pkg::DIV_NUM_W-1:0]   num,
  input  logic [cs9_pkg::DIV_DEN_W-1:0]   den,
  output logic                            busy,
  output logic                            done,
  output logic [cs9_pkg::DIV_NUM_W-1:0]   quo
);

  logic [cs9_pkg::DIV_DEN_W-1:0] den_r;
  logic [cs9_pkg::DIV_DEN_W-1:0] rem;
  logic [cs9_pkg::DIV_CNT_W-1:0] cnt;
  logic [cs9_pkg::DIV_DEN_W:0]   rem_sh;
  logic                          ge;

  assign rem_sh = {rem, quo[cs9_pkg::DIV_NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == cs9_pkg::DIV_CNT_W'(cs9_pkg::DIV_NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo   <= num;
      rem   <= '0;
      den_r <= den;
    end else if (busy) begin
      quo <= {quo[cs9_pkg::DIV_NUM_W-2:0], ge};
      rem <= ge ? cs9_pkg::DIV_DEN_W'(rem_sh - {1'b0, den_r})
                : cs9_pkg::DIV_DEN_W'(rem_sh);
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/cs9_sqrt.sv
// Integer square root, one result bit per cycle.
`default_nettype none

module cs9_sqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [cs9_pkg::SQ_W-1:0]   rad,
  output logic                       busy,
  output logic                       done,
  output logic [cs9_pkg::SQ_W-1:0]   root
);

  logic [cs9_pkg::SQ_W-1:0]     rem;
  logic [cs9_pkg::SQ_W-1:0]     bitv;
  logic [cs9_pkg::SQ_W-1:0]     trial;
  logic [cs9_pkg::SQ_CNT_W-1:0] cnt;

  assign trial = root + bitv;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (&cnt) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= rad;
      root <= '0;
      bitv <= cs9_pkg::SQ_W'(1) << (cs9_pkg::SQ_W - 2);
    end else if (busy) begin
      if (rem >= trial) begin
        rem  <= rem - trial;
        root <= (root >> 1) + bitv;
      end else begin
        root <= root >> 1;
      end
      bitv <= bitv >> 2;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/cs9_core.sv
// Sequencer, shared multiplier and accumulators of the SH9 projection.
`default_nettype none

module cs9_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  cs9_pkg::texel_t               texel,
  input  logic [cs9_pkg::FSZ_W-1:0]     n_in,
  output logic                          idle,
  input  logic                          out_free,
  output logic                          push,
  output cs9_pkg::coeff_t               result
);

  cs9_pkg::state_t state, state_next;

  cs9_pkg::texel_t                    item;
  logic [cs9_pkg::FSZ_W-1:0]          n;
  logic signed [16:0]                 u, v;
  logic [31:0]                        tsum;
  logic [30:0]                        s;
  logic [32:0]                        p;
  logic [15:0]                        w;
  logic [30:0]                        r;
  logic signed [15:0]                 dir [3];
  logic signed [cs9_pkg::BASIS_W-1:0] basis [cs9_pkg::NUM_COEFF];
  logic signed [32:0]                 tmp;
  logic [31:0]                        ws;
  logic signed [cs9_pkg::ACC_W-1:0]   acc [cs9_pkg::NUM_ACC];
  logic [cs9_pkg::WT_W-1:0]           wtot;
  logic [3:0]                         k;
  logic [1:0]                         ch;
  logic [cs9_pkg::PROD_W-1:0]         mk;
  logic signed [31:0]                 cres [3];

  logic signed [cs9_pkg::MUL_W-1:0]  mul_a, mul_b;
  logic signed [cs9_pkg::PROD_W-1:0] prod;

  logic                              div_start, div_busy, div_done;
  logic [cs9_pkg::DIV_NUM_W-1:0]     div_num, div_quo;
  logic [cs9_pkg::DIV_DEN_W-1:0]     div_den;
  logic                              sq_start, sq_busy, sq_done;
  logic [cs9_pkg::SQ_W-1:0]          sq_root;

  // Combinational helpers.
  logic [7:0]                        col_c, row_c;
  logic signed [16:0]                cvec [3];
  logic signed [16:0]                mv;
  logic [cs9_pkg::ACC_IDX_W-1:0]     aidx;
  logic signed [cs9_pkg::ACC_W-1:0]  acc_rd;
  logic [cs9_pkg::ACC_W-1:0]         mag;
  logic signed [cs9_pkg::PROD_W-1:0] sh16, sh20, sh30, sh31;
  logic signed [cs9_pkg::ACC_W:0]    acc_sum;
  logic signed [cs9_pkg::ACC_W-1:0]  acc_new;
  logic [cs9_pkg::WT_W:0]            wt_sum;
  logic signed [15:0]                dn_sat;
  logic signed [31:0]                q_sat;
  logic signed [15:0]                pa, pb;
  logic [15:0]                       sample;

  localparam logic signed [16:0] ONE_Q15 = 17'sd32768;

  cs9_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .busy(div_busy), .done(div_done), .quo(div_quo)
  );

  cs9_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sq_start), .rad({2'b00, tsum, 30'd0}),
    .busy(sq_busy), .done(sq_done), .root(sq_root)
  );

  assign col_c = ({1'b0, item.column} >= n) ? 8'(n - 1'b1) : item.column;
  assign row_c = ({1'b0, item.row} >= n) ? 8'(n - 1'b1) : item.row;
  assign mv    = -v;

  always_comb begin
    cvec[0] = '0;
    cvec[1] = '0;
    cvec[2] = '0;
    case (item.face_index)
      cs9_pkg::FACE_PX: begin
        cvec[0] = ONE_Q15;  cvec[1] = mv;       cvec[2] = -u;
      end
      cs9_pkg::FACE_NX: begin
        cvec[0] = -ONE_Q15; cvec[1] = mv;       cvec[2] = u;
      end
      cs9_pkg::FACE_PY: begin
        cvec[0] = u;        cvec[1] = ONE_Q15;  cvec[2] = v;
      end
      cs9_pkg::FACE_NY: begin
        cvec[0] = u;        cvec[1] = -ONE_Q15; cvec[2] = mv;
      end
      cs9_pkg::FACE_PZ: begin
        cvec[0] = u;        cvec[1] = mv;       cvec[2] = ONE_Q15;
      end
      cs9_pkg::FACE_NZ: begin
        cvec[0] = -u;       cvec[1] = mv;       cvec[2] = -ONE_Q15;
      end
      default: ;
    endcase
  end

  assign aidx   = cs9_pkg::acc_index(k, ch);
  assign acc_rd = acc[aidx];
  assign mag    = acc_rd[cs9_pkg::ACC_W-1] ? (~acc_rd + 1'b1) : acc_rd;

  assign sh16 = cs9_pkg::rnd_shift(prod, 16);
  assign sh20 = cs9_pkg::rnd_shift(prod, 20);
  assign sh30 = cs9_pkg::rnd_shift(prod, 30);
  assign sh31 = cs9_pkg::rnd_shift(prod, 31);

  // Saturating accumulate; the term is well inside 29 bits.
  assign acc_sum = {acc_rd[cs9_pkg::ACC_W-1], acc_rd} + signed'(sh20[cs9_pkg::ACC_W:0]);
  always_comb begin
    if (acc_sum[cs9_pkg::ACC_W] != acc_sum[cs9_pkg::ACC_W-1]) begin
      acc_new = acc_sum[cs9_pkg::ACC_W] ? {1'b1, {(cs9_pkg::ACC_W-1){1'b0}}}
                                        : {1'b0, {(cs9_pkg::ACC_W-1){1'b1}}};
    end else begin
      acc_new = acc_sum[cs9_pkg::ACC_W-1:0];
    end
  end

  assign wt_sum = {1'b0, wtot} + (cs9_pkg::WT_W+1)'(w);

  always_comb begin
    if (sh30 > 68'sd32767) begin
      dn_sat = 16'sd32767;
    end else if (sh30 < -68'sd32767) begin
      dn_sat = -16'sd32767;
    end else begin
      dn_sat = sh30[15:0];
    end
  end

  always_comb begin
    if (acc_rd[cs9_pkg::ACC_W-1]) begin
      q_sat = (|div_quo[cs9_pkg::DIV_NUM_W-1:31]) ? 32'sh8000_0000 : -signed'(div_quo[31:0]);
    end else begin
      q_sat = (|div_quo[cs9_pkg::DIV_NUM_W-1:31]) ? 32'sh7FFF_FFFF : signed'(div_quo[31:0]);
    end
  end

  always_comb begin
    pa = dir[0];
    pb = dir[0];
    case (k)
      4'd4: begin pa = dir[0]; pb = dir[1]; end
      4'd5: begin pa = dir[1]; pb = dir[2]; end
      4'd6: begin pa = dir[2]; pb = dir[2]; end
      4'd7: begin pa = dir[0]; pb = dir[2]; end
      default: ;
    endcase
  end

  always_comb begin
    case (ch)
      2'd0:    sample = item.red_sample;
      2'd1:    sample = item.green_sample;
      default: sample = item.blue_sample;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cs9_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and unit controls.
  always_comb begin
    state_next = state;
    idle       = 1'b0;
    push       = 1'b0;
    div_start  = 1'b0;
    div_num    = '0;
    div_den    = '0;
    sq_start   = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    unique case (state)
      cs9_pkg::ST_IDLE: begin
        idle = 1'b1;
        if (start) begin
          state_next = (texel.face_index > cs9_pkg::FACE_NZ) ? cs9_pkg::ST_FIN
                                                             : cs9_pkg::ST_U_DIV;
        end
      end
      cs9_pkg::ST_U_DIV: begin
        div_start  = 1'b1;
        div_num    = cs9_pkg::DIV_NUM_W'({col_c, 1'b1, 15'd0}) + cs9_pkg::DIV_NUM_W'(n[8:1]);
        div_den    = cs9_pkg::DIV_DEN_W'(n);
        state_next = cs9_pkg::ST_U_WAIT;
      end
      cs9_pkg::ST_U_WAIT: if (div_done) state_next = cs9_pkg::ST_V_DIV;
      cs9_pkg::ST_V_DIV: begin
        div_start  = 1'b1;
        div_num    = cs9_pkg::DIV_NUM_W'({row_c, 1'b1, 15'd0}) + cs9_pkg::DIV_NUM_W'(n[8:1]);
        div_den    = cs9_pkg::DIV_DEN_W'(n);
        state_next = cs9_pkg::ST_V_WAIT;
      end
      cs9_pkg::ST_V_WAIT: if (div_done) state_next = cs9_pkg::ST_UU_MUL;
      cs9_pkg::ST_UU_MUL: begin
        mul_a      = cs9_pkg::MUL_W'(u);
        mul_b      = cs9_pkg::MUL_W'(u);
        state_next = cs9_pkg::ST_UU_GET;
      end
      cs9_pkg::ST_UU_GET: state_next = cs9_pkg::ST_VV_MUL;
      cs9_pkg::ST_VV_MUL: begin
        mul_a      = cs9_pkg::MUL_W'(v);
        mul_b      = cs9_pkg::MUL_W'(v);
        state_next = cs9_pkg::ST_VV_GET;
      end
      cs9_pkg::ST_VV_GET: state_next = cs9_pkg::ST_SQ_START;
      cs9_pkg::ST_SQ_START: begin
        sq_start   = 1'b1;
        state_next = cs9_pkg::ST_SQ_WAIT;
      end
      cs9_pkg::ST_SQ_WAIT: if (sq_done) state_next = cs9_pkg::ST_P_MUL;
      cs9_pkg::ST_P_MUL: begin
        mul_a      = signed'({2'b00, tsum});
        mul_b      = signed'({3'b000, s});
        state_next = cs9_pkg::ST_P_GET;
      end
      cs9_pkg::ST_P_GET: state_next = cs9_pkg::ST_W_DIV;
      cs9_pkg::ST_W_DIV: begin
        div_start  = 1'b1;
        div_num    = (cs9_pkg::DIV_NUM_W'(1) << 45) + cs9_pkg::DIV_NUM_W'(p[32:1]);
        div_den    = cs9_pkg::DIV_DEN_W'(p);
        state_next = cs9_pkg::ST_W_WAIT;
      end
      cs9_pkg::ST_W_WAIT: if (div_done) state_next = cs9_pkg::ST_R_DIV;
      cs9_pkg::ST_R_DIV: begin
        div_start  = 1'b1;
        div_num    = (cs9_pkg::DIV_NUM_W'(1) << 60) + cs9_pkg::DIV_NUM_W'(s[30:1]);
        div_den    = cs9_pkg::DIV_DEN_W'(s);
        state_next = cs9_pkg::ST_R_WAIT;
      end
      cs9_pkg::ST_R_WAIT: if (div_done) state_next = cs9_pkg::ST_N_MUL;
      cs9_pkg::ST_N_MUL: begin
        mul_a      = cs9_pkg::MUL_W'(cvec[ch]);
        mul_b      = signed'({3'b000, r});
        state_next = cs9_pkg::ST_N_GET;
      end
      cs9_pkg::ST_N_GET: state_next = (ch == 2'd2) ? cs9_pkg::ST_B_SEL : cs9_pkg::ST_N_MUL;
      cs9_pkg::ST_B_SEL: state_next = (k < 4'd4) ? cs9_pkg::ST_C_MUL : cs9_pkg::ST_PR_MUL;
      cs9_pkg::ST_PR_MUL: begin
        mul_a      = cs9_pkg::MUL_W'(pa);
        mul_b      = cs9_pkg::MUL_W'(pb);
        state_next = cs9_pkg::ST_PR_GET;
      end
      cs9_pkg::ST_PR_GET: begin
        state_next = (k == 4'd8) ? cs9_pkg::ST_YY_MUL : cs9_pkg::ST_C_MUL;
      end
      cs9_pkg::ST_YY_MUL: begin
        mul_a      = cs9_pkg::MUL_W'(dir[1]);
        mul_b      = cs9_pkg::MUL_W'(dir[1]);
        state_next = cs9_pkg::ST_YY_GET;
      end
      cs9_pkg::ST_YY_GET: state_next = cs9_pkg::ST_C_MUL;
      cs9_pkg::ST_C_MUL: begin
        mul_a      = signed'(cs9_pkg::MUL_W'(cs9_pkg::basis_const(k)));
        mul_b      = cs9_pkg::MUL_W'(tmp);
        state_next = cs9_pkg::ST_C_GET;
      end
      cs9_pkg::ST_C_GET: begin
        state_next = (k == 4'd8) ? cs9_pkg::ST_WS_MUL : cs9_pkg::ST_B_SEL;
      end
      cs9_pkg::ST_WS_MUL: begin
        mul_a      = signed'(cs9_pkg::MUL_W'(w));
        mul_b      = signed'(cs9_pkg::MUL_W'(sample));
        state_next = cs9_pkg::ST_WS_GET;
      end
      cs9_pkg::ST_WS_GET: state_next = cs9_pkg::ST_T_MUL;
      cs9_pkg::ST_T_MUL: begin
        mul_a      = signed'({2'b00, ws});
        mul_b      = cs9_pkg::MUL_W'(basis[k]);
        state_next = cs9_pkg::ST_T_ADD;
      end
      cs9_pkg::ST_T_ADD: begin
        if (k != 4'd8) begin
          state_next = cs9_pkg::ST_T_MUL;
        end else begin
          state_next = (ch == 2'd2) ? cs9_pkg::ST_WT_ADD : cs9_pkg::ST_WS_MUL;
        end
      end
      cs9_pkg::ST_WT_ADD: state_next = cs9_pkg::ST_FIN;
      cs9_pkg::ST_FIN: begin
        state_next = item.final_texel ? cs9_pkg::ST_O_LO_MUL : cs9_pkg::ST_IDLE;
      end
      cs9_pkg::ST_O_LO_MUL: begin
        mul_a      = signed'(cs9_pkg::MUL_W'(mag[23:0]));
        mul_b      = signed'(cs9_pkg::MUL_W'(cs9_pkg::FOURPI_Q16));
        state_next = cs9_pkg::ST_O_LO_GET;
      end
      cs9_pkg::ST_O_LO_GET: state_next = cs9_pkg::ST_O_HI_MUL;
      cs9_pkg::ST_O_HI_MUL: begin
        mul_a      = signed'(cs9_pkg::MUL_W'(mag[47:24]));
        mul_b      = signed'(cs9_pkg::MUL_W'(cs9_pkg::FOURPI_Q16));
        state_next = cs9_pkg::ST_O_HI_GET;
      end
      cs9_pkg::ST_O_HI_GET: state_next = cs9_pkg::ST_O_DIV;
      cs9_pkg::ST_O_DIV: begin
        if (wtot == '0) begin
          state_next = (ch == 2'd2) ? cs9_pkg::ST_O_PUSH : cs9_pkg::ST_O_LO_MUL;
        end else begin
          div_start  = 1'b1;
          div_num    = mk + cs9_pkg::DIV_NUM_W'({wtot, 2'b00});
          div_den    = cs9_pkg::DIV_DEN_W'({wtot, 3'b000});
          state_next = cs9_pkg::ST_O_WAIT;
        end
      end
      cs9_pkg::ST_O_WAIT: begin
        if (div_done) begin
          state_next = (ch == 2'd2) ? cs9_pkg::ST_O_PUSH : cs9_pkg::ST_O_LO_MUL;
        end
      end
      cs9_pkg::ST_O_PUSH: begin
        if (out_free) begin
          push       = 1'b1;
          state_next = (k == cs9_pkg::LAST_COEFF) ? cs9_pkg::ST_IDLE : cs9_pkg::ST_O_LO_MUL;
        end
      end
      default: state_next = cs9_pkg::ST_IDLE;
    endcase
  end

  assign result.coeff_index = k;
  assign result.red_coeff   = cres[0];
  assign result.green_coeff = cres[1];
  assign result.blue_coeff  = cres[2];
  assign result.last_coeff  = (k == cs9_pkg::LAST_COEFF);

  // Shared multiplier, registered.
  always_ff @(posedge clk) begin
    prod <= cs9_pkg::PROD_W'(mul_a) * cs9_pkg::PROD_W'(mul_b);
  end

  // Accumulator state.
  always_ff @(posedge clk) begin
    if (rst) begin
      wtot <= '0;
      for (int i = 0; i < cs9_pkg::NUM_ACC; i++) acc[i] <= '0;
    end else if (state == cs9_pkg::ST_T_ADD) begin
      acc[aidx] <= acc_new;
    end else if (state == cs9_pkg::ST_WT_ADD) begin
      wtot <= wt_sum[cs9_pkg::WT_W] ? '1 : wt_sum[cs9_pkg::WT_W-1:0];
    end else if (state == cs9_pkg::ST_O_PUSH && out_free && k == cs9_pkg::LAST_COEFF) begin
      wtot <= '0;
      for (int i = 0; i < cs9_pkg::NUM_ACC; i++) acc[i] <= '0;
    end
  end

  // Counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      k  <= '0;
      ch <= '0;
    end else begin
      case (state)
        cs9_pkg::ST_R_WAIT: ch <= '0;
        cs9_pkg::ST_N_GET: begin
          ch <= ch + 1'b1;
          k  <= 4'd1;
        end
        cs9_pkg::ST_C_GET: begin
          k  <= (k == 4'd8) ? 4'd0 : k + 1'b1;
          ch <= '0;
        end
        cs9_pkg::ST_T_ADD: begin
          if (k == 4'd8) begin
            k  <= '0;
            ch <= ch + 1'b1;
          end else begin
            k <= k + 1'b1;
          end
        end
        cs9_pkg::ST_FIN: begin
          k  <= '0;
          ch <= '0;
        end
        cs9_pkg::ST_O_DIV: if (wtot == '0) ch <= ch + 1'b1;
        cs9_pkg::ST_O_WAIT: if (div_done) ch <= ch + 1'b1;
        cs9_pkg::ST_O_PUSH: begin
          if (out_free) begin
            k  <= k + 1'b1;
            ch <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      cs9_pkg::ST_IDLE: begin
        if (start) begin
          item <= texel;
          n    <= n_in;
        end
        basis[0] <= cs9_pkg::Y0_VAL;
      end
      cs9_pkg::ST_U_WAIT: if (div_done) u <= signed'(17'(div_quo[15:0]) - 17'd32768);
      cs9_pkg::ST_V_WAIT: if (div_done) v <= signed'(17'(div_quo[15:0]) - 17'd32768);
      cs9_pkg::ST_UU_GET: tsum <= 32'h4000_0000 + prod[31:0];
      cs9_pkg::ST_VV_GET: tsum <= tsum + prod[31:0];
      cs9_pkg::ST_SQ_WAIT: if (sq_done) s <= sq_root[30:0];
      cs9_pkg::ST_P_GET: p <= prod[62:30];
      cs9_pkg::ST_W_WAIT: if (div_done) w <= div_quo[15:0];
      cs9_pkg::ST_R_WAIT: if (div_done) r <= div_quo[30:0];
      cs9_pkg::ST_N_GET: dir[ch] <= dn_sat;
      cs9_pkg::ST_B_SEL: begin
        case (k)
          4'd1:    tmp <= 33'(dir[1]);
          4'd2:    tmp <= 33'(dir[2]);
          default: tmp <= 33'(dir[0]);
        endcase
      end
      cs9_pkg::ST_PR_GET: begin
        if (k == 4'd6) begin
          tmp <= (signed'(prod[32:0]) <<< 1) + signed'(prod[32:0]) - (33'sd1 <<< 30);
        end else begin
          tmp <= signed'(prod[32:0]);
        end
      end
      cs9_pkg::ST_YY_GET: tmp <= tmp - signed'(prod[32:0]);
      cs9_pkg::ST_C_GET: basis[k] <= (k < 4'd4) ? sh16[cs9_pkg::BASIS_W-1:0]
                                                 : sh31[cs9_pkg::BASIS_W-1:0];
      cs9_pkg::ST_WS_GET: ws <= prod[31:0];
      cs9_pkg::ST_O_LO_GET: mk <= prod;
      cs9_pkg::ST_O_HI_GET: mk <= mk + (prod << 24);
      cs9_pkg::ST_O_DIV: if (wtot == '0) cres[ch] <= '0;
      cs9_pkg::ST_O_WAIT: if (div_done) cres[ch] <= q_sat;
      default: ;
    endcase
  end

  a_push_needs_room: assert property (@(posedge clk) disable iff (rst)
    push |-> out_free)
    else $error("result pushed while output register is occupied");

  a_units_quiet_when_idle: assert property (@(posedge clk) disable iff (rst)
    state == cs9_pkg::ST_IDLE |-> !div_busy && !sq_busy)
    else $error("arithmetic unit busy while sequencer is idle");

  a_start_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    start && idle |=> state != cs9_pkg::ST_IDLE)
    else $error("accepted texel did not start the sequence");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    push && result.last_coeff |=> wtot == '0 && state == cs9_pkg::ST_IDLE)
    else $error("state not cleared after the last coefficient");

endmodule

`default_nettype wire
